// ===== rtl/core/abt_pkg.sv =====
// ----------------------------------------------------------------------------
// Array binary tree package
// Shared constants, codes and port structs for the heap-layout tree core.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

    localparam int TREE_SIZE = 16;
    localparam int ADDR_W    = $clog2(TREE_SIZE);
    localparam int CHILD_W   = ADDR_W + 2;
    localparam int WORD_W    = 32;

    localparam logic signed [WORD_W-1:0] EMPTY_MARK = -32'sd999;

    typedef enum logic [1:0] {
        KIND_ROOT  = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DUP_ROOT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EVAL = 2'd2
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_W-1:0] data;
    } wr_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/array_binary_tree_insert_core.sv =====
// ----------------------------------------------------------------------------
// Array binary tree insert core
// Heap-layout binary tree held in a slot memory: make root, insert a left or
// right child under the first slot matching a parent value, or read a slot.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_      | in        | tuser: kind; tdata: parent_value, node_value, read_index
//  m_      | out       | tdata: status, read_value, read_empty
//
// A root or read request reads its slot on acceptance and loads its result
// from S_EVAL; the next request is accepted once the engine returns to S_IDLE.
// An insert scans the slot memory one slot per cycle through its single read
// port in S_SCAN; with no match or a child past the tree it loads its result
// there, else it reads the child slot and loads its result from S_EVAL.
// Reset marks every slot empty at once through per-slot valid bits.
// A new request is accepted while a result waits in the output register; a
// stalled output holds the engine in its final state until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module array_binary_tree_insert_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // parent_value[31:0], node_value[63:32],
                                        // read_index[67:64], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[2:0], read_value[34:3],
                                        // read_empty[35], zero pad
);
    import abt_pkg::*;

    state_t                   state_reg, state_next;
    kind_t                    kind_reg, kind_next;
    logic signed [WORD_W-1:0] parent_reg, parent_next;
    logic signed [WORD_W-1:0] node_reg, node_next;
    logic [ADDR_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]        child_reg, child_next;

    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic signed [WORD_W-1:0] rvalue_reg, rvalue_next;
    logic                     rempty_reg, rempty_next;

    rd_req_t                  rd_req;
    wr_req_t                  wr_req;
    logic signed [WORD_W-1:0] rd_data;

    logic                     s_accept;
    logic                     out_free;
    logic                     out_load;
    logic [CHILD_W-1:0]       child_pos;
    kind_t                    s_kind;

    abt_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (rd_data)
    );

    assign s_kind   = kind_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        child_pos = {1'b0, cmp_idx_reg, 1'b0}
                  + ((kind_reg == KIND_RIGHT) ? CHILD_W'(2) : CHILD_W'(1));
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        parent_next  = parent_reg;
        node_next    = node_reg;
        cmp_idx_next = cmp_idx_reg;
        child_next   = child_reg;
        status_next  = status_reg;
        rvalue_next  = rvalue_reg;
        rempty_next  = rempty_reg;
        out_load     = 1'b0;
        rd_req       = '0;
        wr_req       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    kind_next    = s_kind;
                    parent_next  = s_tdata[31:0];
                    node_next    = s_tdata[63:32];
                    cmp_idx_next = '0;
                    child_next   = '0;
                    rd_req.en    = 1'b1;
                    if (s_kind == KIND_READ) begin
                        rd_req.addr = s_tdata[64 +: ADDR_W];
                        state_next  = S_EVAL;
                    end else if (s_kind == KIND_ROOT) begin
                        rd_req.addr = '0;
                        state_next  = S_EVAL;
                    end else begin
                        rd_req.addr = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_data == parent_reg) begin
                    if (child_pos >= CHILD_W'(TREE_SIZE)) begin
                        if (out_free) begin
                            out_load    = 1'b1;
                            status_next = ST_OVERFLOW;
                            rvalue_next = '0;
                            rempty_next = 1'b0;
                            state_next  = S_IDLE;
                        end
                    end else begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = child_pos[ADDR_W-1:0];
                        child_next  = child_pos[ADDR_W-1:0];
                        state_next  = S_EVAL;
                    end
                end else if (cmp_idx_reg == ADDR_W'(TREE_SIZE - 1)) begin
                    if (out_free) begin
                        out_load    = 1'b1;
                        status_next = ST_NOT_FOUND;
                        rvalue_next = '0;
                        rempty_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end else begin
                    rd_req.en    = 1'b1;
                    rd_req.addr  = cmp_idx_reg + ADDR_W'(1);
                    cmp_idx_next = cmp_idx_reg + ADDR_W'(1);
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    state_next  = S_IDLE;
                    rvalue_next = '0;
                    rempty_next = 1'b0;
                    if (kind_reg == KIND_READ) begin
                        status_next = ST_OK;
                        rvalue_next = rd_data;
                        rempty_next = (rd_data == EMPTY_MARK);
                    end else if (rd_data == EMPTY_MARK) begin
                        status_next = ST_OK;
                        wr_req.en   = 1'b1;
                        wr_req.addr = (kind_reg == KIND_ROOT) ? '0 : child_reg;
                        wr_req.data = node_reg;
                    end else begin
                        status_next = (kind_reg == KIND_ROOT) ? ST_DUP_ROOT : ST_PRESENT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        parent_reg  <= parent_next;
        node_reg    <= node_next;
        cmp_idx_reg <= cmp_idx_next;
        child_reg   <= child_next;
        status_reg  <= status_next;
        rvalue_reg  <= rvalue_next;
        rempty_reg  <= rempty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, rempty_reg, rvalue_reg, status_reg};

    // A slot is only written when its old contents read back as empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_req.en |-> (rd_data == EMPTY_MARK))
        else $error("slot write over an occupied slot");

    // Every slot write is paired with loading a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_req.en |-> out_load)
        else $error("slot write without a result");

    // An accepted insert starts its scan at slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == KIND_LEFT || s_tuser == KIND_RIGHT))
            |=> (state_reg == S_SCAN && cmp_idx_reg == '0))
        else $error("insert scan did not start at slot zero");

endmodule

`default_nettype wire

// ===== rtl/core/abt_store.sv =====
// ----------------------------------------------------------------------------
// Tree slot store
// Synchronous slot memory with a registered read. Each slot has a valid
// bit cleared by reset, and a slot that was never written reads as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_store (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire abt_pkg::rd_req_t                 rd_req,
    input  wire abt_pkg::wr_req_t                 wr_req,
    output logic signed [abt_pkg::WORD_W-1:0]     rd_data
);
    import abt_pkg::*;

    logic signed [WORD_W-1:0] slot_mem [TREE_SIZE];
    logic [TREE_SIZE-1:0]     valid_reg;
    logic signed [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            slot_mem[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.en) begin
            valid_reg[wr_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_data_reg <= valid_reg[rd_req.addr] ? slot_mem[rd_req.addr] : EMPTY_MARK;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
